// File: rtl/ppo_pkg.sv
// ----------------------------------------------------------------------------
// ppo_pkg
// Shared types and constants of the pixel point operation unit.
// ----------------------------------------------------------------------------
package ppo_pkg;

    typedef enum logic [1:0] {
        OP_GREY   = 2'd0,
        OP_NEG    = 2'd1,
        OP_BRIGHT = 2'd2,
        OP_SEPIA  = 2'd3
    } ppo_op_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GREY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_OFS = 2'd3;

    localparam int SAMPLE_W = 8;
    localparam int WEIGHT_W = 10;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int QUOT_W   = 10;

    // floor(x / 1000) = (x * RECIP_K) >> RECIP_SHIFT for every x below 2^SUM_W
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_K = 20'd536871;
    localparam int SCALED_W    = SUM_W + RECIP_W;

    localparam logic [WEIGHT_W-1:0] W_GREY_R  = 10'd299;
    localparam logic [WEIGHT_W-1:0] W_GREY_G  = 10'd587;
    localparam logic [WEIGHT_W-1:0] W_GREY_B  = 10'd114;
    localparam logic [WEIGHT_W-1:0] W_SEP_RR  = 10'd393;
    localparam logic [WEIGHT_W-1:0] W_SEP_RG  = 10'd769;
    localparam logic [WEIGHT_W-1:0] W_SEP_RB  = 10'd189;
    localparam logic [WEIGHT_W-1:0] W_SEP_GR  = 10'd349;
    localparam logic [WEIGHT_W-1:0] W_SEP_GG  = 10'd686;
    localparam logic [WEIGHT_W-1:0] W_SEP_GB  = 10'd168;
    localparam logic [WEIGHT_W-1:0] W_SEP_BR  = 10'd272;
    localparam logic [WEIGHT_W-1:0] W_SEP_BG  = 10'd534;
    localparam logic [WEIGHT_W-1:0] W_SEP_BB  = 10'd131;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } ppo_adv_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] wsum;
        logic [SAMPLE_W-1:0] point;
    } ppo_lane_res_t;

endpackage

// File: rtl/pixel_point_operation_unit.sv
// ----------------------------------------------------------------------------
// pixel_point_operation_unit
// Per-pixel grey conversion, negative, brightness adjust and sepia.
// ----------------------------------------------------------------------------
// Input requests (s_valid/s_ready) carry one pixel: RGB, grey and last flag.
// Result requests (m_valid/m_ready) carry one transformed pixel per input.
// Four channel lanes (red, green, blue, grey) each form a weighted sum in
// thousandths and a negative/brightness result; an output stage selects per
// channel by op_mode and input_is_grey. Unused channels are 0.
// An accepted pixel passes the products, sum, reciprocal multiply and output
// registers before m_valid; one pixel per cycle is sustained while m_ready
// stays high. Each stage advances when empty or when the one after it
// advances, so bubbles collapse while the receiver stalls and s_ready drops
// only once all four stages hold pixels. The user writes configuration via
// cfg_wr_en/cfg_index/cfg_wr_data only while the block is idle, unenforced.
// Reset (aresetn low, synchronous) empties the pipeline and sets op_mode 0,
// input_is_grey 0, peak level 255, brightness_offset 0.
// ----------------------------------------------------------------------------
module pixel_point_operation_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ppo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppo_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_red_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_green_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_blue_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_grey_in,
    input  logic                           s_last_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ppo_pkg::SAMPLE_W-1:0]   m_red_out,
    output logic [ppo_pkg::SAMPLE_W-1:0]   m_green_out,
    output logic [ppo_pkg::SAMPLE_W-1:0]   m_blue_out,
    output logic [ppo_pkg::SAMPLE_W-1:0]   m_grey_out,
    output logic                           m_last_out
);
    import ppo_pkg::*;

    ppo_op_t                    op_mode_reg;
    logic                       input_grey_reg;
    logic [SAMPLE_W-1:0]        peak_level_reg;
    logic signed [SAMPLE_W-1:0] bright_ofs_reg;

    logic          v1_reg, v2_reg, v3_reg;
    logic          last1_reg, last2_reg, last3_reg;
    logic          merge_ready;
    ppo_adv_t      adv;
    ppo_lane_res_t red_res, green_res, blue_res, grey_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= OP_GREY;
            input_grey_reg <= 1'b0;
            peak_level_reg <= 8'd255;
            bright_ofs_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OP_MODE:    op_mode_reg    <= ppo_op_t'(cfg_wr_data[1:0]);
                REG_INPUT_GREY: input_grey_reg <= cfg_wr_data[0];
                REG_MAX_VALUE:  peak_level_reg <= cfg_wr_data;
                REG_BRIGHT_OFS: bright_ofs_reg <= $signed(cfg_wr_data);
                default: begin
                    op_mode_reg <= op_mode_reg;
                end
            endcase
        end
    end

    always_comb begin
        adv.st3 = !v3_reg || merge_ready;
        adv.st2 = !v2_reg || adv.st3;
        adv.st1 = !v1_reg || adv.st2;
    end

    assign s_ready = adv.st1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv.st1) v1_reg <= s_valid;
            if (adv.st2) v2_reg <= v1_reg;
            if (adv.st3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.st1) last1_reg <= s_last_in;
        if (adv.st2) last2_reg <= last1_reg;
        if (adv.st3) last3_reg <= last2_reg;
    end

    ppo_lane u_lane_red (
        .aclk       (aclk),
        .adv        (adv),
        .w_r        (W_SEP_RR),
        .w_g        (W_SEP_RG),
        .w_b        (W_SEP_RB),
        .red        (s_red_in),
        .green      (s_green_in),
        .blue       (s_blue_in),
        .sample     (s_red_in),
        .op_mode    (op_mode_reg),
        .peak_level (peak_level_reg),
        .bright_ofs (bright_ofs_reg),
        .res        (red_res)
    );

    ppo_lane u_lane_green (
        .aclk       (aclk),
        .adv        (adv),
        .w_r        (W_SEP_GR),
        .w_g        (W_SEP_GG),
        .w_b        (W_SEP_GB),
        .red        (s_red_in),
        .green      (s_green_in),
        .blue       (s_blue_in),
        .sample     (s_green_in),
        .op_mode    (op_mode_reg),
        .peak_level (peak_level_reg),
        .bright_ofs (bright_ofs_reg),
        .res        (green_res)
    );

    ppo_lane u_lane_blue (
        .aclk       (aclk),
        .adv        (adv),
        .w_r        (W_SEP_BR),
        .w_g        (W_SEP_BG),
        .w_b        (W_SEP_BB),
        .red        (s_red_in),
        .green      (s_green_in),
        .blue       (s_blue_in),
        .sample     (s_blue_in),
        .op_mode    (op_mode_reg),
        .peak_level (peak_level_reg),
        .bright_ofs (bright_ofs_reg),
        .res        (blue_res)
    );

    ppo_lane u_lane_grey (
        .aclk       (aclk),
        .adv        (adv),
        .w_r        (W_GREY_R),
        .w_g        (W_GREY_G),
        .w_b        (W_GREY_B),
        .red        (s_red_in),
        .green      (s_green_in),
        .blue       (s_blue_in),
        .sample     (s_grey_in),
        .op_mode    (op_mode_reg),
        .peak_level (peak_level_reg),
        .bright_ofs (bright_ofs_reg),
        .res        (grey_res)
    );

    ppo_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v3_reg),
        .in_ready      (merge_ready),
        .red_res       (red_res),
        .green_res     (green_res),
        .blue_res      (blue_res),
        .grey_res      (grey_res),
        .last          (last3_reg),
        .op_mode       (op_mode_reg),
        .input_is_grey (input_grey_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_grey_out    (m_grey_out),
        .m_last_out    (m_last_out)
    );

endmodule

// File: rtl/ppo_lane.sv
// ----------------------------------------------------------------------------
// ppo_lane
// One channel lane: three-stage weighted sum divided by 1000 and clamped,
// carried alongside the negative or brightness result of its own sample.
// ----------------------------------------------------------------------------
module ppo_lane (
    input  logic                              aclk,
    input  ppo_pkg::ppo_adv_t                 adv,
    input  logic [ppo_pkg::WEIGHT_W-1:0]      w_r,
    input  logic [ppo_pkg::WEIGHT_W-1:0]      w_g,
    input  logic [ppo_pkg::WEIGHT_W-1:0]      w_b,
    input  logic [ppo_pkg::SAMPLE_W-1:0]      red,
    input  logic [ppo_pkg::SAMPLE_W-1:0]      green,
    input  logic [ppo_pkg::SAMPLE_W-1:0]      blue,
    input  logic [ppo_pkg::SAMPLE_W-1:0]      sample,
    input  ppo_pkg::ppo_op_t                  op_mode,
    input  logic [ppo_pkg::SAMPLE_W-1:0]      peak_level,
    input  logic signed [ppo_pkg::SAMPLE_W-1:0] bright_ofs,
    output ppo_pkg::ppo_lane_res_t            res
);
    import ppo_pkg::*;

    logic [PROD_W-1:0]    prod_r_reg, prod_g_reg, prod_b_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [SAMPLE_W-1:0]  pt1_reg, pt2_reg, pt3_reg;
    logic [SAMPLE_W-1:0]  pt_next;
    logic [SAMPLE_W-1:0]  neg_val;
    logic [SAMPLE_W-1:0]  bright_val;
    logic signed [SAMPLE_W+1:0] sum_lo;
    logic [SAMPLE_W:0]    sum_hi;
    logic [SCALED_W-1:0]  scaled;

    always_comb begin
        neg_val = peak_level - sample;
        sum_lo  = $signed({2'b00, sample}) + $signed({{2{bright_ofs[SAMPLE_W-1]}}, bright_ofs});
        sum_hi  = {1'b0, sample} + {1'b0, bright_ofs};
        if (bright_ofs[SAMPLE_W-1]) begin
            bright_val = sum_lo[SAMPLE_W+1] ? '0 : sum_lo[SAMPLE_W-1:0];
        end else begin
            bright_val = (sum_hi > {1'b0, peak_level}) ? peak_level : sum_hi[SAMPLE_W-1:0];
        end
        pt_next = (op_mode == OP_NEG) ? neg_val : bright_val;
        scaled  = SCALED_W'(sum_reg) * SCALED_W'(RECIP_K);
    end

    always_ff @(posedge aclk) begin
        if (adv.st1) begin
            prod_r_reg <= PROD_W'(w_r) * PROD_W'(red);
            prod_g_reg <= PROD_W'(w_g) * PROD_W'(green);
            prod_b_reg <= PROD_W'(w_b) * PROD_W'(blue);
            pt1_reg    <= pt_next;
        end
        if (adv.st2) begin
            sum_reg <= SUM_W'(prod_r_reg) + SUM_W'(prod_g_reg) + SUM_W'(prod_b_reg);
            pt2_reg <= pt1_reg;
        end
        if (adv.st3) begin
            quot_reg <= scaled[RECIP_SHIFT +: QUOT_W];
            pt3_reg  <= pt2_reg;
        end
    end

    assign res.wsum  = (quot_reg > QUOT_W'(255)) ? 8'd255 : quot_reg[SAMPLE_W-1:0];
    assign res.point = pt3_reg;

endmodule

// File: rtl/ppo_merge.sv
// ----------------------------------------------------------------------------
// ppo_merge
// Output stage: picks each channel from the lanes by operation and holds
// the finished pixel until the receiver takes it.
// ----------------------------------------------------------------------------
module ppo_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ppo_pkg::ppo_lane_res_t       red_res,
    input  ppo_pkg::ppo_lane_res_t       green_res,
    input  ppo_pkg::ppo_lane_res_t       blue_res,
    input  ppo_pkg::ppo_lane_res_t       grey_res,
    input  logic                         last,
    input  ppo_pkg::ppo_op_t             op_mode,
    input  logic                         input_is_grey,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ppo_pkg::SAMPLE_W-1:0] m_red_out,
    output logic [ppo_pkg::SAMPLE_W-1:0] m_green_out,
    output logic [ppo_pkg::SAMPLE_W-1:0] m_blue_out,
    output logic [ppo_pkg::SAMPLE_W-1:0] m_grey_out,
    output logic                         m_last_out
);
    import ppo_pkg::*;

    logic                valid_reg;
    logic [SAMPLE_W-1:0] red_reg, green_reg, blue_reg, grey_reg;
    logic                last_reg;
    logic [SAMPLE_W-1:0] red_next, green_next, blue_next, grey_next;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        grey_next  = '0;
        unique case (op_mode)
            OP_GREY: begin
                grey_next = grey_res.wsum;
            end
            OP_NEG, OP_BRIGHT: begin
                if (input_is_grey) begin
                    grey_next = grey_res.point;
                end else begin
                    red_next   = red_res.point;
                    green_next = green_res.point;
                    blue_next  = blue_res.point;
                end
            end
            OP_SEPIA: begin
                red_next   = red_res.wsum;
                green_next = green_res.wsum;
                blue_next  = blue_res.wsum;
            end
            default: begin
                grey_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            grey_reg  <= grey_next;
            last_reg  <= last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;
    assign m_grey_out  = grey_reg;
    assign m_last_out  = last_reg;

endmodule

// File: sim/ppo_pixel_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppo_pixel_check
// Watches the pixel point operation unit and compares each result pixel.
// ----------------------------------------------------------------------------
// Follows the register writes to keep a copy of the settings. Computes the
// expected output pixel for every accepted input request and queues it.
// Compares each accepted result field by field with the oldest queued pixel.
// Exports the mismatch count and the number of pixels still expected.
// ----------------------------------------------------------------------------
module ppo_pixel_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ppo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppo_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_red_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_green_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_blue_in,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   s_grey_in,
    input  logic                           s_last_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   m_red_out,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   m_green_out,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   m_blue_out,
    input  logic [ppo_pkg::SAMPLE_W-1:0]   m_grey_out,
    input  logic                           m_last_out,
    output int                             mismatch_count,
    output int                             pixels_in_flight
);
    import ppo_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] grey;
        logic                last;
    } pixel_t;

    ppo_op_t                    op_mode = OP_GREY;
    logic                       in_grey = 1'b0;
    logic [SAMPLE_W-1:0]        max_val = 8'd255;
    logic signed [SAMPLE_W-1:0] bright_ofs = 8'sd0;

    pixel_t expected_q[$];
    pixel_t seen_px;
    pixel_t due_px;

    function automatic logic [SAMPLE_W-1:0] weighted_floor(
        logic [WEIGHT_W-1:0] wr, logic [WEIGHT_W-1:0] wg, logic [WEIGHT_W-1:0] wb,
        pixel_t px
    );
        int unsigned acc;
        acc = (32'(wr) * 32'(px.red) + 32'(wg) * 32'(px.green)
               + 32'(wb) * 32'(px.blue)) / 1000;
        if (acc > 255) acc = 255;
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] brighten(logic [SAMPLE_W-1:0] s);
        int sum;
        sum = int'(s) + int'(bright_ofs);
        if (bright_ofs < 0) return (sum < 0) ? 8'd0 : sum[SAMPLE_W-1:0];
        return (sum > int'(max_val)) ? max_val : sum[SAMPLE_W-1:0];
    endfunction

    function automatic pixel_t transform_pixel(pixel_t px);
        pixel_t res;
        res = '0;
        res.last = px.last;
        case (op_mode)
            OP_GREY: begin
                res.grey = weighted_floor(W_GREY_R, W_GREY_G, W_GREY_B, px);
            end
            OP_NEG: begin
                if (in_grey) begin
                    res.grey = max_val - px.grey;
                end else begin
                    res.red   = max_val - px.red;
                    res.green = max_val - px.green;
                    res.blue  = max_val - px.blue;
                end
            end
            OP_BRIGHT: begin
                if (in_grey) begin
                    res.grey = brighten(px.grey);
                end else begin
                    res.red   = brighten(px.red);
                    res.green = brighten(px.green);
                    res.blue  = brighten(px.blue);
                end
            end
            default: begin
                res.red   = weighted_floor(W_SEP_RR, W_SEP_RG, W_SEP_RB, px);
                res.green = weighted_floor(W_SEP_GR, W_SEP_GG, W_SEP_GB, px);
                res.blue  = weighted_floor(W_SEP_BR, W_SEP_BG, W_SEP_BB, px);
            end
        endcase
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        if (mismatch_count < 40)
            $display("%0t ppo check: %s got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            op_mode    = OP_GREY;
            in_grey    = 1'b0;
            max_val    = 8'd255;
            bright_ofs = 8'sd0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(transform_pixel(
                    {s_red_in, s_green_in, s_blue_in, s_grey_in, s_last_in}));
            if (m_valid && m_ready) begin
                seen_px = {m_red_out, m_green_out, m_blue_out, m_grey_out, m_last_out};
                if (expected_q.size() == 0) begin
                    report("result with no pending request, last", seen_px.last, 0);
                end else begin
                    due_px = expected_q.pop_front();
                    if (seen_px.red !== due_px.red)
                        report("red", seen_px.red, due_px.red);
                    if (seen_px.green !== due_px.green)
                        report("green", seen_px.green, due_px.green);
                    if (seen_px.blue !== due_px.blue)
                        report("blue", seen_px.blue, due_px.blue);
                    if (seen_px.grey !== due_px.grey)
                        report("grey", seen_px.grey, due_px.grey);
                    if (seen_px.last !== due_px.last)
                        report("last", seen_px.last, due_px.last);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OP_MODE:    op_mode    = ppo_op_t'(cfg_wr_data[1:0]);
                    REG_INPUT_GREY: in_grey    = cfg_wr_data[0];
                    REG_MAX_VALUE:  max_val    = cfg_wr_data;
                    REG_BRIGHT_OFS: bright_ofs = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pixels_in_flight = expected_q.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pixel point operation unit.
// ----------------------------------------------------------------------------
// Runs a short directed set over every operation and the value extremes,
// then random images under many register settings, with bursty input
// requests and a receiver that stalls in segments and once for a long hold.
// Checking is done by ppo_pixel_check; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb;
    import ppo_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_PIXELS   = 106;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [SAMPLE_W-1:0]     s_red_in;
    logic [SAMPLE_W-1:0]     s_green_in;
    logic [SAMPLE_W-1:0]     s_blue_in;
    logic [SAMPLE_W-1:0]     s_grey_in;
    logic                    s_last_in;
    logic                    m_valid;
    logic                    m_ready;
    logic [SAMPLE_W-1:0]     m_red_out;
    logic [SAMPLE_W-1:0]     m_green_out;
    logic [SAMPLE_W-1:0]     m_blue_out;
    logic [SAMPLE_W-1:0]     m_grey_out;
    logic                    m_last_out;
    int                      mismatch_count;
    int                      pixels_in_flight;

    int                      burst_left = 0;
    int                      idle_cycles = 0;
    logic [SAMPLE_W-1:0]     cur_max = 8'd255;
    bit                      long_hold = 1'b0;
    bit                      hold_done = 1'b0;

    pixel_point_operation_unit dut (.*);
    ppo_pixel_check chk (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: segments of differing stall density, one long hold on request
    initial begin
        int seg_left;
        int seg_style;
        seg_left  = 0;
        seg_style = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_done) begin
                m_ready = 1'b0;
                repeat (120) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (seg_left == 0) begin
                seg_left  = $urandom_range(10, 150);
                seg_style = $urandom_range(0, 3);
            end
            seg_left--;
            case (seg_style)
                0: m_ready = 1'b1;
                1: m_ready = ($urandom_range(0, 1) == 1);
                2: m_ready = ($urandom_range(0, 99) < 85);
                default: m_ready = ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    task automatic offer(logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                         logic [SAMPLE_W-1:0] b, logic [SAMPLE_W-1:0] a, logic last);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid    = 1'b1;
        s_red_in   = r;
        s_green_in = g;
        s_blue_in  = b;
        s_grey_in  = a;
        s_last_in  = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pixels_in_flight != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_config(ppo_op_t op, logic grey, logic [SAMPLE_W-1:0] mx,
                              logic signed [SAMPLE_W-1:0] ofs);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_index   = REG_OP_MODE;
        cfg_wr_data = {6'($urandom), op};
        @(negedge aclk);
        cfg_index   = REG_INPUT_GREY;
        cfg_wr_data = {7'($urandom), grey};
        @(negedge aclk);
        cfg_index   = REG_MAX_VALUE;
        cfg_wr_data = mx;
        @(negedge aclk);
        cfg_index   = REG_BRIGHT_OFS;
        cfg_wr_data = ofs;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cur_max     = mx;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return cur_max;
            3: return cur_max + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        logic last;
        logic [SAMPLE_W-1:0] mx;
        logic signed [SAMPLE_W-1:0] ofs;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_OP_MODE;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_red_in    = '0;
        s_green_in  = '0;
        s_blue_in   = '0;
        s_grey_in   = '0;
        s_last_in   = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // grey conversion under reset settings, primaries and extremes
        offer(8'd0, 8'd0, 8'd0, 8'd9, 1'b0);
        offer(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
        offer(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        offer(8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
        offer(8'd0, 8'd0, 8'd255, 8'd0, 1'b1);

        // sepia saturates at white; grey input flag is ignored
        set_config(OP_SEPIA, 1'b1, 8'd255, 8'sd0);
        offer(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        offer(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        offer(8'd200, 8'd100, 8'd50, 8'd0, 1'b1);

        set_config(OP_NEG, 1'b0, 8'd255, 8'sd0);
        offer(8'd0, 8'd128, 8'd255, 8'd77, 1'b1);

        // negative with samples above the maximum wraps
        set_config(OP_NEG, 1'b1, 8'd100, 8'sd0);
        offer(8'd1, 8'd2, 8'd3, 8'd200, 1'b0);
        offer(8'd1, 8'd2, 8'd3, 8'd0, 1'b0);
        offer(8'd1, 8'd2, 8'd3, 8'd100, 1'b1);

        set_config(OP_NEG, 1'b1, 8'd0, 8'sd0);
        offer(8'd0, 8'd0, 8'd0, 8'd1, 1'b1);

        set_config(OP_BRIGHT, 1'b0, 8'd255, -8'sd128);
        offer(8'd0, 8'd127, 8'd255, 8'd5, 1'b1);

        set_config(OP_BRIGHT, 1'b1, 8'd200, 8'sd127);
        offer(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        offer(8'd0, 8'd0, 8'd0, 8'd100, 1'b0);
        offer(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);

        // zero maximum clamps any non-negative offset result to zero
        set_config(OP_BRIGHT, 1'b0, 8'd0, 8'sd0);
        offer(8'd5, 8'd0, 8'd255, 8'd0, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: mx = 8'd255;
                1: mx = 8'd1;
                2: mx = 8'd0;
                default: mx = 8'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 6))
                0: ofs = -8'sd128;
                1: ofs = 8'sd127;
                2: ofs = 8'sd0;
                3: ofs = -8'sd1;
                default: ofs = 8'($urandom);
            endcase
            set_config(ppo_op_t'(ph % 4 == 0 ? $urandom_range(0, 3) : ph % 4),
                       1'($urandom), mx, ofs);
            long_hold = (ph == 5);
            sent = 0;
            while (sent < PHASE_PIXELS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 12);
                if (len > PHASE_PIXELS - sent) len = PHASE_PIXELS - sent;
                for (int i = 0; i < len; i++) begin
                    last = (i == len - 1);
                    if ($urandom_range(0, 19) == 0) last = !last;
                    offer(pick_sample(), pick_sample(), pick_sample(), pick_sample(), last);
                end
                sent += len;
            end
            long_hold = 1'b0;
        end

        drain();
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/ppo_pkg.sv
rtl/ppo_lane.sv
rtl/ppo_merge.sv
rtl/pixel_point_operation_unit.sv
sim/ppo_pixel_check.sv
sim/tb.sv
